// File: src/shpl_pkg.sv
// Package for the sorted hash pair lookup block.
// Payload structs, operation and status codes, controller state type,
// and the command/status structs between controller and datapath. No dependencies.
package shpl_pkg;

    localparam int KEY_W   = 160;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key_high;
        logic [63:0] key_mid;
        logic [31:0] key_low;
        logic [63:0] code_high;
        logic [63:0] code_mid;
        logic [31:0] code_low;
    } shpl_req_t;

    typedef struct packed {
        logic               listed;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } shpl_rsp_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SEARCH_RD,
        CS_SEARCH_CMP,
        CS_SCAN_RD,
        CS_SCAN_CMP,
        CS_REPLY
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the accepted request
        logic exec;        // apply clear / append, set initial result
        logic srch_init;   // lo = 0, hi = count
        logic rd_mid;      // read entry at midpoint
        logic lo_step;     // lo = mid + 1
        logic hi_step;     // hi = mid
        logic rd_lo;       // read entry at lo (scan)
        logic scan_next;   // lo = lo + 1
        logic set_found;   // listed = 1
        logic finish;      // load output register
    } shpl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       table_empty;
        logic       lo_lt_hi;
        logic       lo_lt_cnt;
        logic       prim_lt;
        logic       prim_eq;
        logic       sec_eq;
        logic       out_free;
    } shpl_sts_t;

endpackage

// File: src/shpl_chan_if.sv
// Valid/ready channel interface carrying one payload struct.
// Payload type is set per instance (shpl_req_t / shpl_rsp_t from shpl_pkg).
interface shpl_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/shpl_ctrl.sv
// Controller FSM for the lookup block: sequences exec, binary search and scan.
// Depends on shpl_pkg (state enum, command/status structs).
module shpl_ctrl
    import shpl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  shpl_sts_t sts,
    output shpl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                    state_next = CS_EXEC;
            end
            CS_EXEC:
            begin
                if (sts.func == FUNC_QUERY && !sts.table_empty)
                    state_next = CS_SEARCH_RD;
                else
                    state_next = CS_REPLY;
            end
            CS_SEARCH_RD:
            begin
                if (sts.lo_lt_hi)
                    state_next = CS_SEARCH_CMP;
                else
                    state_next = CS_SCAN_RD;
            end
            CS_SEARCH_CMP:
            begin
                state_next = CS_SEARCH_RD;
            end
            CS_SCAN_RD:
            begin
                if (sts.lo_lt_cnt)
                    state_next = CS_SCAN_CMP;
                else
                    state_next = CS_REPLY;
            end
            CS_SCAN_CMP:
            begin
                if (!sts.prim_eq || sts.sec_eq)
                    state_next = CS_REPLY;
                else
                    state_next = CS_SCAN_RD;
            end
            CS_REPLY:
            begin
                if (sts.out_free)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            CS_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.srch_init = 1'b1;
            end
            CS_SEARCH_RD:
            begin
                cmd.rd_mid = sts.lo_lt_hi;
            end
            CS_SEARCH_CMP:
            begin
                cmd.lo_step = sts.prim_lt;
                cmd.hi_step = !sts.prim_lt;
            end
            CS_SCAN_RD:
            begin
                cmd.rd_lo = sts.lo_lt_cnt;
            end
            CS_SCAN_CMP:
            begin
                cmd.set_found = sts.prim_eq && sts.sec_eq;
                cmd.scan_next = sts.prim_eq && !sts.sec_eq;
            end
            CS_REPLY:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/shpl_dpath.sv
// Datapath: request register, entry memory, search bounds, result and output register.
// Depends on shpl_pkg and shpl_chan_if; driven by shpl_ctrl commands.
module shpl_dpath
    import shpl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  shpl_req_t req_data,
    input  shpl_cmd_t cmd,
    output shpl_sts_t sts,
    shpl_chan_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 2 * KEY_W;
    localparam int EXT_W = CNT_W + COUNT_W;

    // request
    logic [1:0]       func_reg;
    logic [KEY_W-1:0] pkey_reg;
    logic [KEY_W-1:0] skey_reg;

    // table state
    logic [CNT_W-1:0] count_reg;
    logic             rejected_reg;
    logic [KEY_W-1:0] last_key_reg;

    // search
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid;

    // memory: {primary, secondary}
    logic [ENT_W-1:0] mem [TABLE_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [KEY_W-1:0] rd_prim;
    logic [KEY_W-1:0] rd_sec;

    // result
    logic             res_listed_reg;
    logic [1:0]       res_status_reg;
    logic             out_valid_reg;
    shpl_rsp_t        out_data_reg;
    logic [EXT_W-1:0] cnt_ext;

    logic full;
    logic order_bad;

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign full      = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign order_bad = (count_reg != '0) && (pkey_reg < last_key_reg);
    assign wr_en     = cmd.exec && (func_reg == FUNC_APPEND) && !rejected_reg
                       && !full && !order_bad;
    assign rd_en     = cmd.rd_mid || cmd.rd_lo;
    assign rd_addr   = cmd.rd_mid ? mid[IDX_W-1:0] : lo_reg[IDX_W-1:0];
    assign rd_prim   = rd_data_reg[ENT_W-1:KEY_W];
    assign rd_sec    = rd_data_reg[KEY_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= {pkey_reg, skey_reg};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= req_data.func;
            pkey_reg <= {req_data.key_high, req_data.key_mid, req_data.key_low};
            skey_reg <= {req_data.code_high, req_data.code_mid, req_data.code_low};
        end
        if (wr_en)
            last_key_reg <= pkey_reg;
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= count_reg;
        end
        else if (cmd.lo_step)
            lo_reg <= mid + CNT_W'(1);
        else if (cmd.hi_step)
            hi_reg <= mid;
        else if (cmd.scan_next)
            lo_reg <= lo_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rejected_reg   <= 1'b0;
            res_listed_reg <= 1'b0;
            res_status_reg <= STATUS_OK;
        end
        else
        begin
            if (cmd.exec)
            begin
                res_listed_reg <= 1'b0;
                res_status_reg <= STATUS_OK;
                unique case (func_reg)
                    FUNC_CLEAR:
                    begin
                        count_reg    <= '0;
                        rejected_reg <= 1'b0;
                    end
                    FUNC_APPEND:
                    begin
                        priority if (rejected_reg)
                            res_status_reg <= STATUS_REJECTED;
                        else if (full)
                            res_status_reg <= STATUS_FULL;
                        else if (order_bad)
                        begin
                            count_reg      <= '0;
                            rejected_reg   <= 1'b1;
                            res_status_reg <= STATUS_REJECTED;
                        end
                        else
                            count_reg <= count_reg + CNT_W'(1);
                    end
                    default:
                    begin
                        // query and unused code leave the table alone
                    end
                endcase
            end
            else if (cmd.set_found)
                res_listed_reg <= 1'b1;
        end
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.listed      <= res_listed_reg;
            out_data_reg.status      <= res_status_reg;
            out_data_reg.entry_count <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign sts.func        = func_reg;
    assign sts.table_empty = (count_reg == '0);
    assign sts.lo_lt_hi    = (lo_reg < hi_reg);
    assign sts.lo_lt_cnt   = (lo_reg < count_reg);
    assign sts.prim_lt     = (rd_prim < pkey_reg);
    assign sts.prim_eq     = (rd_prim == pkey_reg);
    assign sts.sec_eq      = (rd_sec == skey_reg);
    assign sts.out_free    = !out_valid_reg || rsp.ready;

endmodule

// File: src/sorted_hash_pair_lookup_core.sv
// Top level of the sorted hash pair lookup block: controller plus datapath.
// Depends on shpl_pkg, shpl_chan_if, shpl_ctrl, shpl_dpath.
//
//  channel | dir | payload     | transaction
//  --------+-----+-------------+-----------------------------------------------
//  req     | in  | shpl_req_t  | clear / append / query with primary + secondary key
//  rsp     | out | shpl_rsp_t  | listed, status, entry_count (one per req)
//
// Clear, append and unused codes pass through accept, execute and reply.
// A query on a non-empty table adds binary-search steps (at most
// floor(log2(entry_count))+1 steps) and a check to leave the search, then one scan step
// per entry in the equal-key range, plus a final check if the scan runs to the table end;
// each step is one registered read of the entry memory plus a 160-bit compare.
// Reset (rst_n, async low) empties the table and clears the reject flag; memory
// contents are not cleared since only entries below the count are read.
// One request is in flight at a time; a stalled rsp holds the reply stage until taken.
module sorted_hash_pair_lookup_core
    import shpl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    shpl_chan_if.sink   req,
    shpl_chan_if.source rsp
);

    shpl_cmd_t cmd;
    shpl_sts_t sts;

    // FSM: owns the request handshake and all sequencing
    shpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: entry memory, bounds, compares, output register
    shpl_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule
